/* rtl/dq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg: shared types and constants of the double-ended queue
// Command codes, controller states and the controller-to-datapath bundle.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned CmdW   = 3;
  localparam int unsigned CountW = 5;

  localparam logic [DataW-1:0] EmptyValue = {DataW{1'b1}};

  typedef enum logic [CmdW-1:0] {
    CMD_QUERY      = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_PUSH_FRONT = 3'd2,
    CMD_POP_FRONT  = 3'd3,
    CMD_POP_BACK   = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_LOAD
  } state_e;

  typedef struct packed {
    logic accept;      // item taken, update indices and store
    logic capture_rd;  // register the two slot reads
    logic load_out;    // move result into the output register
  } dq_ctrl_t;

endpackage

/* rtl/dq_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_in_if: command channel
// Valid/ready channel carrying one command item.
// ----------------------------------------------------------------------------
interface dq_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [31:0] push_value;

  modport source (output valid, output cmd, output push_value, input ready);
  modport sink   (input valid, input cmd, input push_value, output ready);
endinterface

// ----------------------------------------------------------------------------
// dq_out_if: result channel
// Valid/ready channel carrying one result item.
// ----------------------------------------------------------------------------
interface dq_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] front_value;
  logic [31:0] back_value;
  logic [4:0]  count;
  logic        is_empty;
  logic        is_full;
  logic        op_error;

  modport source (output valid, output front_value, output back_value, output count,
                  output is_empty, output is_full, output op_error, input ready);
  modport sink   (input valid, input front_value, input back_value, input count,
                  input is_empty, input is_full, input op_error, output ready);
endinterface

/* rtl/dq_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_ctrl: sequencing of one command
// Accept, slot read, then hand-off into the output register.
// ----------------------------------------------------------------------------
module dq_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output dq_pkg::dq_ctrl_t ctrl_o
);
  import dq_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_READ;
      S_READ: state_d = S_LOAD;
      S_LOAD: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        ctrl_o.accept = in_valid_i;
      end
      S_READ: ctrl_o.capture_rd = 1'b1;
      S_LOAD: ctrl_o.load_out = out_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_accept_to_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_READ))
    else $error("accepted item did not start slot read");

  a_read_to_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |=> (state_q == S_LOAD))
    else $error("slot read not followed by load");

  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.load_out |=> out_valid_q)
    else $error("result load lost");

endmodule

/* rtl/dq_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_datapath: ring store, indices, fill count and result register
// Two-read, one-write store; read data and result are registered.
// ----------------------------------------------------------------------------
module dq_datapath #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  dq_pkg::dq_ctrl_t          ctrl_i,
  input  logic [dq_pkg::CmdW-1:0]   cmd_i,
  input  logic [dq_pkg::DataW-1:0]  push_value_i,
  output logic [dq_pkg::DataW-1:0]  front_value_o,
  output logic [dq_pkg::DataW-1:0]  back_value_o,
  output logic [dq_pkg::CountW-1:0] count_o,
  output logic                      is_empty_o,
  output logic                      is_full_o,
  output logic                      op_error_o
);
  import dq_pkg::*;

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned FillW = $clog2(CAPACITY + 1);
  localparam logic [IdxW-1:0]  LastIdx  = IdxW'(CAPACITY - 1);
  localparam logic [FillW-1:0] FullFill = FillW'(CAPACITY);

  function automatic logic [IdxW-1:0] idx_next(input logic [IdxW-1:0] i);
    return (i == LastIdx) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IdxW-1:0] idx_prev(input logic [IdxW-1:0] i);
    return (i == '0) ? LastIdx : i - 1'b1;
  endfunction

  logic [DataW-1:0] mem [CAPACITY];

  logic [IdxW-1:0]  front_q, front_d, back_q, back_d, wr_addr;
  logic [FillW-1:0] fill_q, fill_d;
  logic             wr_en, err_d, err_q;
  logic             full, empty;
  logic [DataW-1:0] rd_front_q, rd_back_q;
  logic [DataW-1:0] res_front_q, res_back_q;
  logic [CountW-1:0] res_count_q;
  logic             res_empty_q, res_full_q, res_err_q;

  assign full  = (fill_q == FullFill);
  assign empty = (fill_q == '0);

  always_comb begin
    front_d = front_q;
    back_d  = back_q;
    fill_d  = fill_q;
    wr_en   = 1'b0;
    wr_addr = back_q;
    err_d   = 1'b0;
    unique case (cmd_e'(cmd_i))
      CMD_PUSH_BACK: begin
        if (full) begin
          err_d = 1'b1;
        end else begin
          wr_en  = 1'b1;
          back_d = idx_next(back_q);
          fill_d = fill_q + 1'b1;
        end
      end
      CMD_PUSH_FRONT: begin
        if (full) begin
          err_d = 1'b1;
        end else begin
          wr_en   = 1'b1;
          wr_addr = idx_prev(front_q);
          front_d = idx_prev(front_q);
          fill_d  = fill_q + 1'b1;
        end
      end
      CMD_POP_FRONT: begin
        if (empty) begin
          err_d = 1'b1;
        end else begin
          front_d = idx_next(front_q);
          fill_d  = fill_q - 1'b1;
        end
      end
      CMD_POP_BACK: begin
        if (empty) begin
          err_d = 1'b1;
        end else begin
          back_d = idx_prev(back_q);
          fill_d = fill_q - 1'b1;
        end
      end
      default: ;  // query and unused codes
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      back_q  <= '0;
      fill_q  <= '0;
    end else if (ctrl_i.accept) begin
      front_q <= front_d;
      back_q  <= back_d;
      fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept) begin
      err_q <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.accept && wr_en) begin
      mem[wr_addr] <= push_value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture_rd) begin
      rd_front_q <= mem[front_q];
      rd_back_q  <= mem[idx_prev(back_q)];
    end
  end

  // empty queue reports -1 at both ends
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_out) begin
      res_front_q <= empty ? EmptyValue : rd_front_q;
      res_back_q  <= empty ? EmptyValue : rd_back_q;
      res_count_q <= CountW'(fill_q);
      res_empty_q <= empty;
      res_full_q  <= full;
      res_err_q   <= err_q;
    end
  end

  assign front_value_o = res_front_q;
  assign back_value_o  = res_back_q;
  assign count_o       = res_count_q;
  assign is_empty_o    = res_empty_q;
  assign is_full_o     = res_full_q;
  assign op_error_o    = res_err_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FullFill)
    else $error("fill count beyond capacity");

  a_error_keeps_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.accept && err_d) |=> (fill_q == $past(fill_q) && front_q == $past(front_q)
                                  && back_q == $past(back_q)))
    else $error("rejected command changed the queue");

endmodule

/* rtl/double_ended_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue: bounded deque of signed 32-bit values
// Ring store with front/back indices and fill count, one result per command.
// ----------------------------------------------------------------------------
// Usage:
//   in_s  : command items (cmd, push_value). cmd 0 query, 1 push back,
//           2 push front, 3 pop front, 4 pop back; other codes act as query.
//   out_s : one result item per command: front/back value (-1 when empty),
//           count, is_empty, is_full and op_error (push on full or pop on
//           empty, in which case the queue is left unchanged).
//   Each command runs in order through accept and update, registered
//   read of the two end slots, load of the result register. No new
//   command is taken before the last one has loaded its result, but
//   the next command is taken while a result waits in the output
//   register; a stalled receiver holds the third step until the
//   output register frees up.
//   Reset empties the queue (indices and count cleared, no clearing pass);
//   slot contents are not reset and only live slots are reported.
// ----------------------------------------------------------------------------
module double_ended_queue #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  dq_in_if.sink    in_s,
  dq_out_if.source out_s
);
  import dq_pkg::*;

  dq_ctrl_t ctrl;

  dq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_s.valid),
    .in_ready_o  (in_s.ready),
    .out_valid_o (out_s.valid),
    .out_ready_i (out_s.ready),
    .ctrl_o      (ctrl)
  );

  dq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctrl_i        (ctrl),
    .cmd_i         (in_s.cmd),
    .push_value_i  (in_s.push_value),
    .front_value_o (out_s.front_value),
    .back_value_o  (out_s.back_value),
    .count_o       (out_s.count),
    .is_empty_o    (out_s.is_empty),
    .is_full_o     (out_s.is_full),
    .op_error_o    (out_s.op_error)
  );

endmodule
